### rtl/core/pap_pkg.sv
// Package for the proximity adjacency pairs core: sizes, stored-entry type,
// index helper. No dependencies.
package pap_pkg;

	localparam int MAX_FRAGMENTS = 64;
	localparam int IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);
	localparam int OUT_IDX_W = 6;
	localparam int POS_W = 24;
	localparam int EXT_W = 24;
	localparam int SCL_W = 16;
	localparam int SCALED_W = EXT_W + SCL_W;
	localparam int THR_W = 24;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [SCALED_W-1:0] scaled_x;
		logic [SCALED_W-1:0] scaled_y;
		logic [SCALED_W-1:0] scaled_z;
		logic mesh;
	} entry_t;

	// low six bits of a store index, zero-extended first for small stores
	function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [IDX_W-1:0] i);
		logic [IDX_W+OUT_IDX_W-1:0] w;
		w = {{OUT_IDX_W{1'b0}}, i};
		return w[OUT_IDX_W-1:0];
	endfunction

endpackage

### rtl/core/pap_cell.sv
// One storage cell of the fragment ring; loads its neighbor's entry when enabled.
// Depends on pap_pkg.
module pap_cell (
	input  logic            clk,
	input  logic            en,
	input  pap_pkg::entry_t d,
	output pap_pkg::entry_t ent
);

	pap_pkg::entry_t ent_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ent_q <= d;
		end
	end

	assign ent = ent_q;

endmodule

### rtl/core/pap_cmp.sv
// Five-stage adjacency test of a stored entry against the new fragment.
// Depends on pap_pkg.
module pap_cmp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic                         in_end,
	input  logic [pap_pkg::IDX_W-1:0]    in_idx,
	input  pap_pkg::entry_t              a,
	input  pap_pkg::entry_t              b,
	input  logic [pap_pkg::THR_W-1:0]    thr,
	output logic                         hit,
	output logic                         done,
	output logic [pap_pkg::IDX_W-1:0]    hit_idx
);

	localparam int SUM_W = pap_pkg::SCALED_W + 1;
	localparam int GAP_W = SUM_W + 1;

	logic [4:0] vld_q, end_q;
	logic [pap_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;

	// stage 1
	logic [24:0] dx_s1, dy_s1, dz_s1;
	logic [SUM_W-1:0] sx_s1, sy_s1, sz_s1;
	logic mesh_s1;
	logic [pap_pkg::THR_W-1:0] thr_s1;
	// stage 2
	logic [49:0] qx_s2, qy_s2, qz_s2;
	logic [SUM_W-1:0] mx_s2;
	logic [pap_pkg::THR_W-1:0] thr_s2;
	// stage 3
	logic [51:0] d2_s3, d2_s4, d2_s5;
	logic big_s3, big_s4, big_s5;
	logic [16:0] hi_s3, lo_s3;
	// stage 4
	logic [33:0] hh_s4, hl_s4, ll_s4;
	// stage 5
	logic [52:0] gsq_s5;

	function automatic logic [24:0] absdiff(input logic signed [23:0] p,
		input logic signed [23:0] q);
		logic signed [24:0] d;
		d = 25'({p[23], p}) - 25'({q[23], q});
		return d[24] ? 25'(-d) : 25'(d);
	endfunction

	logic [SUM_W-1:0] sx_c, sy_c, sz_c, mxy_c, mx_c;
	logic [GAP_W-1:0] gap_c;

	assign sx_c  = {1'b0, a.scaled_x} + {1'b0, b.scaled_x};
	assign sy_c  = {1'b0, a.scaled_y} + {1'b0, b.scaled_y};
	assign sz_c  = {1'b0, a.scaled_z} + {1'b0, b.scaled_z};
	assign mxy_c = (sy_s1 > sx_s1) ? sy_s1 : sx_s1;
	assign mx_c  = (sz_s1 > mxy_c) ? sz_s1 : mxy_c;
	assign gap_c = GAP_W'({thr_s2, 8'd0}) + GAP_W'(mx_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			end_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[3:0], in_vld};
			end_q <= {end_q[3:0], in_end};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= in_idx;
			dx_s1   <= absdiff(a.pos_x, b.pos_x);
			dy_s1   <= absdiff(a.pos_y, b.pos_y);
			dz_s1   <= absdiff(a.pos_z, b.pos_z);
			sx_s1   <= sx_c;
			sy_s1   <= sy_c;
			sz_s1   <= sz_c;
			mesh_s1 <= a.mesh & b.mesh;
			thr_s1  <= thr;

			idx_s2 <= idx_s1;
			qx_s2  <= dx_s1 * dx_s1;
			qy_s2  <= dy_s1 * dy_s1;
			qz_s2  <= dz_s1 * dz_s1;
			mx_s2  <= mesh_s1 ? mx_c : '0;
			thr_s2 <= thr_s1;

			idx_s3 <= idx_s2;
			d2_s3  <= 52'(qx_s2) + 52'(qy_s2) + 52'(qz_s2);
			big_s3 <= |gap_c[GAP_W-1:34];
			hi_s3  <= gap_c[33:17];
			lo_s3  <= gap_c[16:0];

			idx_s4 <= idx_s3;
			d2_s4  <= d2_s3;
			big_s4 <= big_s3;
			hh_s4  <= hi_s3 * hi_s3;
			hl_s4  <= hi_s3 * lo_s3;
			ll_s4  <= lo_s3 * lo_s3;

			idx_s5 <= idx_s4;
			d2_s5  <= d2_s4;
			big_s5 <= big_s4;
			gsq_s5 <= 53'({hh_s4, 18'd0}) + 53'({hl_s4, 2'd0}) + 53'(ll_s4[33:16]);
		end
	end

	assign hit     = vld_q[4] & (big_s5 | ({1'b0, d2_s5} <= gsq_s5));
	assign done    = end_q[4];
	assign hit_idx = idx_s5;

endmodule

### rtl/core/proximity_adjacency_pairs_core.sv
// Top level of the proximity adjacency pairs core: fragment ring, compare
// pipeline, pair output. Depends on pap_pkg, pap_cell, pap_cmp.
//
// channel | direction | handshake            | payload
// cfg     | in        | cfg_we               | cfg_wdata (gap threshold)
// in      | in        | in_valid / in_ready  | first, pos_*, has_mesh, extent_*, scale_*
// out     | out       | out_valid / out_ready| index_a, index_b, last_pair, overflow
//
// A fragment is accepted, then scanned while the stored entries rotate once around
// the ring of cells, and then the compare pipeline drains: one compare per cycle
// while the output is not stalled. A fragment on a full store is not stored and
// gives one word. Reset clears the fragment count and threshold; entries hold no reset.
// A stalled output word freezes the ring and the pipeline together.
module proximity_adjacency_pairs_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pap_pkg::THR_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           first,
	input  logic signed [23:0]             pos_x,
	input  logic signed [23:0]             pos_y,
	input  logic signed [23:0]             pos_z,
	input  logic                           has_mesh,
	input  logic [23:0]                    extent_x,
	input  logic [23:0]                    extent_y,
	input  logic [23:0]                    extent_z,
	input  logic [15:0]                    scale_x,
	input  logic [15:0]                    scale_y,
	input  logic [15:0]                    scale_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [5:0]                     index_a,
	output logic [5:0]                     index_b,
	output logic                           last_pair,
	output logic                           overflow
);

	localparam int N = pap_pkg::MAX_FRAGMENTS;
	localparam int IW = pap_pkg::IDX_W;
	localparam int CW = pap_pkg::CNT_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_OVF   = 4'b1000
	} state_t;

	state_t state_q;
	logic [pap_pkg::THR_W-1:0] thr_q;
	logic [CW-1:0] count_q, n_q;
	logic [IW-1:0] i_q;
	pap_pkg::entry_t new_q;
	pap_pkg::entry_t ring [N];
	pap_pkg::entry_t tail_d;

	logic out_free, adv, accept, full, scan_adv;
	logic cmp_vld, cmp_end, hit, done;
	logic [IW-1:0] hit_idx;
	logic pend_v_q;
	logic [IW-1:0] pend_idx_q;
	logic [CW-1:0] i_ext;
	logic ovf_emit, mid_emit, end_emit, emit;

	assign out_free = ~out_valid | out_ready;
	assign adv      = out_free;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign full     = (count_q == CW'(N)) & ~first;
	assign scan_adv = (state_q == S_SCAN) & adv;
	assign i_ext    = CW'(i_q);
	assign cmp_vld  = (state_q == S_SCAN) & (i_ext < n_q);
	assign cmp_end  = (state_q == S_SCAN) & (i_q == IW'(N - 1));
	// head moves to the tail; the new fragment takes its slot at its own index
	assign tail_d   = (i_ext == n_q) ? new_q : ring[0];

	// a hit is held until the next one or the end word shows whether it is last
	assign ovf_emit = (state_q == S_OVF) & out_free;
	assign mid_emit = adv & hit & pend_v_q;
	assign end_emit = adv & ~hit & done & pend_v_q;
	assign emit     = ovf_emit | mid_emit | end_emit;

	for (genvar k = 0; k < N; k++) begin : g_ring
		pap_cell u_cell (
			.clk (clk),
			.en  (scan_adv),
			.d   ((k == N - 1) ? tail_d : ring[(k + 1) % N]),
			.ent (ring[k])
		);
	end

	pap_cmp u_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (cmp_vld),
		.in_end  (cmp_end),
		.in_idx  (i_q),
		.a       (ring[0]),
		.b       (new_q),
		.thr     (thr_q),
		.hit     (hit),
		.done    (done),
		.hit_idx (hit_idx)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.pos_x    <= pos_x;
			new_q.pos_y    <= pos_y;
			new_q.pos_z    <= pos_z;
			new_q.scaled_x <= extent_x * scale_x;
			new_q.scaled_y <= extent_y * scale_y;
			new_q.scaled_z <= extent_z * scale_z;
			new_q.mesh     <= has_mesh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			thr_q      <= '0;
			count_q    <= '0;
			n_q        <= '0;
			i_q        <= '0;
			pend_v_q   <= 1'b0;
			pend_idx_q <= '0;
			out_valid  <= 1'b0;
			index_a    <= '0;
			index_b    <= '0;
			last_pair  <= 1'b0;
			overflow   <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end

			if (emit) begin
				out_valid <= 1'b1;
				index_a   <= ovf_emit ? '0 : pap_pkg::out_idx(pend_idx_q);
				index_b   <= ovf_emit ? '0 : pap_pkg::out_idx(n_q[IW-1:0]);
				last_pair <= ~mid_emit;
				overflow  <= ovf_emit;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (full) begin
							state_q <= S_OVF;
						end else begin
							n_q     <= first ? '0 : count_q;
							count_q <= first ? CW'(1) : count_q + CW'(1);
							i_q     <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (adv) begin
						i_q <= i_q + IW'(1);
						if (i_q == IW'(N - 1)) begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					if (adv && done) begin
						state_q <= S_IDLE;
					end
				end
				S_OVF: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (adv) begin
				if (hit) begin
					pend_v_q   <= 1'b1;
					pend_idx_q <= hit_idx;
				end else if (done) begin
					pend_v_q <= 1'b0;
				end
			end
		end
	end

endmodule

### tb/sv/tb_proximity_adjacency_pairs_core.sv
// Self-checking bench for proximity_adjacency_pairs_core: directed and random fragment
// sets, with a predictor of the pair stream. Depends on pap_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_proximity_adjacency_pairs_core;

	localparam int WATCHDOG = 20000;
	localparam int NF = pap_pkg::MAX_FRAGMENTS;
	localparam int SETTLE = NF + 20;
	localparam logic [23:0] THR_MAX = 24'hFFFFFF;

	typedef struct {
		logic first;
		logic signed [23:0] px, py, pz;
		logic mesh;
		logic [23:0] ex, ey, ez;
		logic [15:0] sx, sy, sz;
	} frag_t;

	typedef struct {
		logic [5:0] a, b;
		logic last, ovf;
	} pair_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [pap_pkg::THR_W-1:0] cfg_wdata;
	logic in_valid, in_ready, out_valid, out_ready;
	logic first, has_mesh;
	logic signed [23:0] pos_x, pos_y, pos_z;
	logic [23:0] extent_x, extent_y, extent_z;
	logic [15:0] scale_x, scale_y, scale_z;
	logic [5:0] index_a, index_b;
	logic last_pair, overflow;

	frag_t frag_q[$];
	pair_t pairs_q[$];
	int errors = 0;
	int idle_cycles = 0;
	logic in_taken = 0;
	int in_gap = 0, out_gap = 0;
	logic no_idle = 1;

	// predictor state
	logic [23:0] thr_m = 0;
	int stored_n = 0;
	logic signed [23:0] st_px[NF], st_py[NF], st_pz[NF];
	logic [39:0] st_sx[NF], st_sy[NF], st_sz[NF];
	logic st_mesh[NF];

	proximity_adjacency_pairs_core uut (.*);

	always begin
		clk = 1; #5;
		clk = 0; #5;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [79:0] sq_delta(logic signed [23:0] a, logic signed [23:0] b);
		logic signed [25:0] d;
		logic [79:0] m;
		d = 26'(a) - 26'(b);
		if (d < 0) d = -d;
		m = 80'(unsigned'(d));
		return m * m;
	endfunction

	function automatic logic near(int i, int n);
		logic [79:0] d2, gap, s1, s2, s3, mx;
		d2 = sq_delta(st_px[i], st_px[n]) + sq_delta(st_py[i], st_py[n])
			+ sq_delta(st_pz[i], st_pz[n]);
		gap = 80'(thr_m) << 8;
		if (st_mesh[i] && st_mesh[n]) begin
			s1 = 80'(st_sx[i]) + 80'(st_sx[n]);
			s2 = 80'(st_sy[i]) + 80'(st_sy[n]);
			s3 = 80'(st_sz[i]) + 80'(st_sz[n]);
			mx = s1;
			if (s2 > mx) mx = s2;
			if (s3 > mx) mx = s3;
			gap += mx;
		end
		if (gap >= (80'd1 << 34)) return 1;
		return d2 <= ((gap * gap) >> 16);
	endfunction

	function automatic void predict_pairs(frag_t f);
		pair_t p;
		int n, hits;
		hits = 0;
		if (f.first) stored_n = 0;
		if (stored_n >= NF) begin
			p.a = 0; p.b = 0; p.last = 1; p.ovf = 1;
			pairs_q.push_back(p);
			return;
		end
		n = stored_n;
		st_px[n] = f.px; st_py[n] = f.py; st_pz[n] = f.pz;
		st_mesh[n] = f.mesh;
		st_sx[n] = 40'(f.ex) * 40'(f.sx);
		st_sy[n] = 40'(f.ey) * 40'(f.sy);
		st_sz[n] = 40'(f.ez) * 40'(f.sz);
		stored_n = n + 1;
		for (int i = 0; i < n; i++) begin
			if (near(i, n)) begin
				p.a = 6'(i); p.b = 6'(n); p.last = 0; p.ovf = 0;
				pairs_q.push_back(p);
				hits++;
			end
		end
		if (hits > 0) begin
			p = pairs_q.pop_back();
			p.last = 1;
			pairs_q.push_back(p);
		end
	endfunction

	task automatic report(string what, logic [7:0] got, logic [7:0] want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// accept, predict, check, watchdog
	always @(posedge clk) begin
		pair_t e;
		frag_t f;
		in_taken <= in_valid && in_ready;
		if (cfg_we) thr_m = cfg_wdata;
		if (in_valid && in_ready) begin
			f.first = first; f.px = pos_x; f.py = pos_y; f.pz = pos_z;
			f.mesh = has_mesh; f.ex = extent_x; f.ey = extent_y; f.ez = extent_z;
			f.sx = scale_x; f.sy = scale_y; f.sz = scale_z;
			predict_pairs(f);
		end
		if (out_valid && out_ready) begin
			if (pairs_q.size() == 0) begin
				report("unexpected word, index_a", 8'(index_a), 8'd0);
			end else begin
				e = pairs_q.pop_front();
				if (index_a !== e.a) report("index_a", 8'(index_a), 8'(e.a));
				if (index_b !== e.b) report("index_b", 8'(index_b), 8'(e.b));
				if (last_pair !== e.last) report("last_pair", 8'(last_pair), 8'(e.last));
				if (overflow !== e.ovf) report("overflow", 8'(overflow), 8'(e.ovf));
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= WATCHDOG) begin
			$display("watchdog expired");
			$display("Regression FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// input driver
	always @(negedge clk) begin
		frag_t f;
		if (!arst_n) begin
			in_valid <= 0;
		end else if (!in_valid || in_taken) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 0;
			end else if (frag_q.size() > 0) begin
				f = frag_q.pop_front();
				first <= f.first; pos_x <= f.px; pos_y <= f.py; pos_z <= f.pz;
				has_mesh <= f.mesh; extent_x <= f.ex; extent_y <= f.ey; extent_z <= f.ez;
				scale_x <= f.sx; scale_y <= f.sy; scale_z <= f.sz;
				in_valid <= 1;
				in_gap <= pick_gap();
			end else
				in_valid <= 0;
		end
	end

	// output stalls
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			out_gap <= pick_gap();
		end
	end

	function automatic frag_t mk(logic fst, logic signed [23:0] x, logic signed [23:0] y,
		logic signed [23:0] z, logic m, logic [23:0] e, logic [15:0] s);
		frag_t f;
		f.first = fst; f.px = x; f.py = y; f.pz = z; f.mesh = m;
		f.ex = e; f.ey = e; f.ez = e; f.sx = s; f.sy = s; f.sz = s;
		return f;
	endfunction

	function automatic frag_t rnd_frag(logic fst, int cx, int cy, int cz, bit noise);
		frag_t f;
		f.first = fst;
		f.mesh = 1'($urandom_range(0, 1));
		if (noise) begin
			f.px = 24'($urandom); f.py = 24'($urandom); f.pz = 24'($urandom);
			f.ex = 24'($urandom); f.ey = 24'($urandom); f.ez = 24'($urandom);
			f.sx = 16'($urandom); f.sy = 16'($urandom); f.sz = 16'($urandom);
		end else begin
			f.px = 24'(cx + $urandom_range(0, 800) - 400);
			f.py = 24'(cy + $urandom_range(0, 800) - 400);
			f.pz = 24'(cz + $urandom_range(0, 800) - 400);
			f.ex = 24'($urandom_range(0, 200)); f.ey = 24'($urandom_range(0, 200));
			f.ez = 24'($urandom_range(0, 200));
			f.sx = 16'($urandom_range(0, 512)); f.sy = 16'($urandom_range(0, 512));
			f.sz = 16'($urandom_range(0, 512));
		end
		return f;
	endfunction

	task automatic drain();
		wait (frag_q.size() == 0 && !in_valid);
		wait (pairs_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_thr(logic [23:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		int sent, sz, cx, cy, cz, sets;
		arst_n = 0; cfg_we = 0; cfg_wdata = 0; in_valid = 0; out_ready = 0;
		first = 0; has_mesh = 0; pos_x = 0; pos_y = 0; pos_z = 0;
		extent_x = 0; extent_y = 0; extent_z = 0; scale_x = 0; scale_y = 0; scale_z = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// threshold zero: only coincident or mesh-overlapping fragments pair up
		write_thr(24'd0);
		frag_q.push_back(mk(1, 0, 0, 0, 1, 24'd16, 16'd256));
		frag_q.push_back(mk(0, 16, 0, 0, 0, 0, 0));
		frag_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));
		frag_q.push_back(mk(0, 40, 0, 0, 1, 24'd16, 16'd256));
		frag_q.push_back(mk(0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1, 24'hFFFFFF,
			16'hFFFF));
		frag_q.push_back(mk(0, -24'sh800000, -24'sh800000, -24'sh800000, 1, 24'hFFFFFF,
			16'hFFFF));
		frag_q.push_back(mk(0, -24'sh800000, 24'sh7FFFFF, 0, 0, 24'hFFFFFF, 16'hFFFF));
		frag_q.push_back(mk(1, 100, 100, 100, 0, 0, 0));
		frag_q.push_back(mk(0, 100, 100, 100, 0, 0, 0));
		drain();
		write_thr(THR_MAX);
		frag_q.push_back(mk(1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0));
		frag_q.push_back(mk(0, -24'sh800000, -24'sh800000, -24'sh800000, 0, 0, 0));
		frag_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));
		frag_q.push_back(mk(0, 24'sh7FFFFF, -24'sh800000, 0, 1, 24'h000010, 16'h0100));
		frag_q.push_back(mk(0, 5, 5, 5, 1, 24'h000010, 16'h0100));
		drain();
		write_thr(24'd32);
		frag_q.push_back(mk(1, 0, 0, 0, 0, 0, 0));
		frag_q.push_back(mk(0, 32, 0, 0, 0, 0, 0));
		frag_q.push_back(mk(0, 0, 33, 0, 0, 0, 0));
		frag_q.push_back(mk(0, 0, 0, -32, 0, 0, 0));
		drain();

		no_idle = 0;
		sent = 0;
		sets = 0;
		while (sent < 280) begin
			sets++;
			if (sets % 6 == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: write_thr(24'd0);
					1: write_thr(THR_MAX);
					2: write_thr(24'($urandom));
					default: write_thr(24'($urandom_range(0, 4000)));
				endcase
			end
			if (sets % 9 == 4) no_idle = ~no_idle;
			sz = (sets % 25 == 10) ? NF + 3 : $urandom_range(2, 12);
			cx = $signed(24'($urandom)); cy = $signed(24'($urandom));
			cz = $signed(24'($urandom));
			cx = cx / 2; cy = cy / 2; cz = cz / 2;
			for (int k = 0; k < sz; k++) begin
				frag_q.push_back(rnd_frag(k == 0 || $urandom_range(0, 99) < 2, cx, cy, cz,
					$urandom_range(0, 99) < 12));
				sent++;
			end
			wait (frag_q.size() == 0);
		end
		drain();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/core/pap_pkg.sv
rtl/core/pap_cell.sv
rtl/core/pap_cmp.sv
rtl/core/proximity_adjacency_pairs_core.sv
tb/sv/tb_proximity_adjacency_pairs_core.sv
